FILE: hw/rtl/pat_pkg.sv
// Shared constants, codes and control structs for the pose authority tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pat_pkg;

    localparam int COUNT_W    = 16;
    localparam int POS_W      = 24;
    localparam int STAMP_W    = 32;
    localparam int YAW_W      = 16;
    localparam int AUTH_W     = 2;
    localparam int UPD_W      = 32;
    localparam int OUT_CNT_W  = 16;
    localparam int DIST_W     = 25;

    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_W     = DIFF_W + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    localparam logic [DIST_W-1:0]    DIST_MAX    = '1;
    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

    localparam logic       OP_SAMPLE = 1'b0;
    localparam logic       OP_UPDATE = 1'b1;

    localparam logic [AUTH_W-1:0] AUTH_MEASURED  = 2'd0;
    localparam logic [AUTH_W-1:0] AUTH_PREDICTED = 2'd1;
    localparam logic [AUTH_W-1:0] AUTH_RECOVERY  = 2'd2;
    localparam logic [AUTH_W-1:0] AUTH_INVALID   = 2'd3;

    typedef struct packed {
        logic load;
        logic square;
        logic root_start;
        logic commit;
        logic emit;
    } pat_cmd_t;

    typedef struct packed {
        logic needs_root;
        logic root_done;
    } pat_status_t;

endpackage

FILE: hw/rtl/pat_sqrt.sv
// Iterative restoring integer square root, one result bit per cycle.
// Depends on pat_pkg for widths.
`timescale 1ns / 1ps

module pat_sqrt
    import pat_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [ROOT_W:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;

    logic [ROOT_W+2:0]     rem_try;
    logic [ROOT_W+2:0]     trial;
    logic [ROOT_W+2:0]     rem_sub;
    logic                  fits;

    assign rem_try = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign rem_sub = rem_try - trial;
    assign fits    = rem_try >= trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        priority if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            // remainder stays below 2*root + 1, so it fits ROOT_W+1 bits
            rem_next  = fits ? rem_sub[ROOT_W:0] : rem_try[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], fits};
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == ROOT_CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hw/rtl/pat_dp.sv
// Datapath: input word capture, tracker state, squares, root unit and output word.
// Depends on pat_pkg and pat_sqrt.
`timescale 1ns / 1ps

module pat_dp
    import pat_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pat_cmd_t             cmd,
    output pat_status_t          st,
    input  logic                 s_op,
    input  logic [AUTH_W-1:0]    s_sample_authority,
    input  logic                 s_sample_finite,
    input  logic [STAMP_W-1:0]   s_stamp_ms,
    input  logic [POS_W-1:0]     s_pose_x,
    input  logic [POS_W-1:0]     s_pose_y,
    input  logic [YAW_W-1:0]     s_pose_yaw,
    output logic [AUTH_W-1:0]    m_authority_now,
    output logic                 m_reference_valid,
    output logic [OUT_CNT_W-1:0] m_predicted_run,
    output logic [STAMP_W-1:0]   m_predicted_duration_ms,
    output logic [OUT_CNT_W-1:0] m_frames_since_ref,
    output logic [STAMP_W-1:0]   m_time_since_ref_ms,
    output logic [DIST_W-1:0]    m_distance_since_ref,
    output logic [YAW_W-1:0]     m_yaw_since_ref,
    output logic [UPD_W-1:0]     m_updates_measured,
    output logic [UPD_W-1:0]     m_updates_predicted
);

    function automatic logic [STAMP_W-1:0] clamp_diff(input logic [STAMP_W-1:0] now_v,
                                                      input logic [STAMP_W-1:0] then_v);
        return (now_v >= then_v) ? now_v - then_v : '0;
    endfunction

    // captured word
    logic               op_reg;
    logic [AUTH_W-1:0]  auth_reg;
    logic               finite_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [POS_W-1:0]   x_reg, y_reg;
    logic [YAW_W-1:0]   yaw_reg;

    // tracker state
    logic [AUTH_W-1:0]  last_auth_reg, last_auth_next;
    logic               ref_valid_reg, ref_valid_next;
    logic [STAMP_W-1:0] ref_stamp_reg, ref_stamp_next;
    logic [POS_W-1:0]   ref_x_reg, ref_x_next;
    logic [POS_W-1:0]   ref_y_reg, ref_y_next;
    logic [YAW_W-1:0]   ref_yaw_reg, ref_yaw_next;
    logic [STAMP_W-1:0] run_start_reg, run_start_next;
    logic [COUNT_W-1:0] run_count_reg, run_count_next;
    logic [STAMP_W-1:0] run_dur_reg, run_dur_next;
    logic [COUNT_W-1:0] frames_reg, frames_next;
    logic [STAMP_W-1:0] elapsed_reg, elapsed_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [YAW_W-1:0]   yaw_delta_reg, yaw_delta_next;
    logic [UPD_W-1:0]   upd_meas_reg, upd_meas_next;
    logic [UPD_W-1:0]   upd_pred_reg, upd_pred_next;

    logic [SQ_W-1:0]    sq_x_reg, sq_y_reg;

    logic [DIFF_W-1:0]  dx, dy, ax, ay;
    logic [RAD_W-1:0]   radicand;
    logic [ROOT_W-1:0]  root;
    logic               root_done;
    logic [DIST_W-1:0]  dist_clamped;
    logic [YAW_W-1:0]   yaw_wrap;
    logic [STAMP_W-1:0] run_start_eff;

    assign dx = {x_reg[POS_W-1], x_reg} - {ref_x_reg[POS_W-1], ref_x_reg};
    assign dy = {y_reg[POS_W-1], y_reg} - {ref_y_reg[POS_W-1], ref_y_reg};
    assign ax = dx[DIFF_W-1] ? -dx : dx;
    assign ay = dy[DIFF_W-1] ? -dy : dy;

    assign radicand = RAD_W'(sq_x_reg) + RAD_W'(sq_y_reg);

    pat_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    assign dist_clamped = (64'(root) > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(root);
    assign yaw_wrap     = yaw_reg - ref_yaw_reg;
    assign run_start_eff = (run_count_reg == '0) ? stamp_reg : run_start_reg;

    assign st.needs_root = (op_reg == OP_SAMPLE) && finite_reg &&
                           (auth_reg != AUTH_MEASURED) && ref_valid_reg;
    assign st.root_done  = root_done;

    always_comb begin
        last_auth_next = last_auth_reg;
        ref_valid_next = ref_valid_reg;
        ref_stamp_next = ref_stamp_reg;
        ref_x_next     = ref_x_reg;
        ref_y_next     = ref_y_reg;
        ref_yaw_next   = ref_yaw_reg;
        run_start_next = run_start_reg;
        run_count_next = run_count_reg;
        run_dur_next   = run_dur_reg;
        frames_next    = frames_reg;
        elapsed_next   = elapsed_reg;
        dist_next      = dist_reg;
        yaw_delta_next = yaw_delta_reg;
        upd_meas_next  = upd_meas_reg;
        upd_pred_next  = upd_pred_reg;
        if (cmd.commit) begin
            priority if (op_reg == OP_UPDATE) begin
                if (auth_reg == AUTH_MEASURED && upd_meas_reg != '1) begin
                    upd_meas_next = upd_meas_reg + 1'b1;
                end
                if (auth_reg == AUTH_PREDICTED && upd_pred_reg != '1) begin
                    upd_pred_next = upd_pred_reg + 1'b1;
                end
            end else if (!finite_reg) begin
                last_auth_next = AUTH_INVALID;
                run_count_next = '0;
                run_dur_next   = '0;
                run_start_next = '0;
            end else if (auth_reg == AUTH_MEASURED) begin
                last_auth_next = auth_reg;
                ref_valid_next = 1'b1;
                ref_stamp_next = stamp_reg;
                ref_x_next     = x_reg;
                ref_y_next     = y_reg;
                ref_yaw_next   = yaw_reg;
                run_count_next = '0;
                run_dur_next   = '0;
                run_start_next = '0;
                frames_next    = '0;
                elapsed_next   = '0;
                dist_next      = '0;
                yaw_delta_next = '0;
            end else begin
                last_auth_next = auth_reg;
                if (ref_valid_reg) begin
                    if (frames_reg != '1) begin
                        frames_next = frames_reg + 1'b1;
                    end
                    elapsed_next   = clamp_diff(stamp_reg, ref_stamp_reg);
                    dist_next      = dist_clamped;
                    // half turn maps to itself
                    yaw_delta_next = yaw_wrap[YAW_W-1] ? -yaw_wrap : yaw_wrap;
                end
                if (auth_reg == AUTH_PREDICTED) begin
                    run_start_next = run_start_eff;
                    if (run_count_reg != '1) begin
                        run_count_next = run_count_reg + 1'b1;
                    end
                    run_dur_next = clamp_diff(stamp_reg, run_start_eff);
                end else begin
                    run_count_next = '0;
                    run_dur_next   = '0;
                    run_start_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_auth_reg <= AUTH_MEASURED;
            ref_valid_reg <= 1'b0;
            ref_stamp_reg <= '0;
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
            ref_yaw_reg   <= '0;
            run_start_reg <= '0;
            run_count_reg <= '0;
            run_dur_reg   <= '0;
            frames_reg    <= '0;
            elapsed_reg   <= '0;
            dist_reg      <= '0;
            yaw_delta_reg <= '0;
            upd_meas_reg  <= '0;
            upd_pred_reg  <= '0;
        end else begin
            last_auth_reg <= last_auth_next;
            ref_valid_reg <= ref_valid_next;
            ref_stamp_reg <= ref_stamp_next;
            ref_x_reg     <= ref_x_next;
            ref_y_reg     <= ref_y_next;
            ref_yaw_reg   <= ref_yaw_next;
            run_start_reg <= run_start_next;
            run_count_reg <= run_count_next;
            run_dur_reg   <= run_dur_next;
            frames_reg    <= frames_next;
            elapsed_reg   <= elapsed_next;
            dist_reg      <= dist_next;
            yaw_delta_reg <= yaw_delta_next;
            upd_meas_reg  <= upd_meas_next;
            upd_pred_reg  <= upd_pred_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_op;
            auth_reg   <= s_sample_authority;
            finite_reg <= s_sample_finite;
            stamp_reg  <= s_stamp_ms;
            x_reg      <= s_pose_x;
            y_reg      <= s_pose_y;
            yaw_reg    <= s_pose_yaw;
        end
        if (cmd.square) begin
            sq_x_reg <= SQ_W'(ax) * SQ_W'(ax);
            sq_y_reg <= SQ_W'(ay) * SQ_W'(ay);
        end
        if (cmd.emit) begin
            m_authority_now         <= last_auth_reg;
            m_reference_valid       <= ref_valid_reg;
            m_predicted_run         <= (33'(run_count_reg) > 33'(OUT_CNT_MAX)) ?
                                       OUT_CNT_MAX : OUT_CNT_W'(run_count_reg);
            m_predicted_duration_ms <= run_dur_reg;
            m_frames_since_ref      <= (33'(frames_reg) > 33'(OUT_CNT_MAX)) ?
                                       OUT_CNT_MAX : OUT_CNT_W'(frames_reg);
            m_time_since_ref_ms     <= elapsed_reg;
            m_distance_since_ref    <= dist_reg;
            m_yaw_since_ref         <= yaw_delta_reg;
            m_updates_measured      <= upd_meas_reg;
            m_updates_predicted     <= upd_pred_reg;
        end
    end

endmodule

FILE: hw/rtl/pat_ctrl.sv
// Controller FSM: input/output handshake and sequencing of the datapath.
// Depends on pat_pkg.
`timescale 1ns / 1ps

module pat_ctrl
    import pat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output pat_cmd_t    cmd,
    input  pat_status_t st
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = st.needs_root ? ST_START : ST_COMMIT;
            end
            ST_START: begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT: begin
                if (st.root_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_to_square: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SQUARE))
        else $error("accepted word did not start the square step");

    a_root_start_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.root_start |=> (state_reg == ST_ROOT))
        else $error("root start not followed by root wait");

    a_done_in_root: assert property (@(posedge aclk) disable iff (!aresetn)
        st.root_done |-> (state_reg == ST_ROOT))
        else $error("root done outside root wait");

    a_commit_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (state_reg == ST_EMIT))
        else $error("commit not followed by emit");

    a_emit_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("output word overwritten before taken");

endmodule

FILE: hw/rtl/pose_authority_tracker.sv
// Pose authority tracker top level: one result word per input word.
// Update records, non-finite, measured and no-reference samples pass from the square
// step straight to commit and emit; samples that need the distance first wait on the
// 26-step one-bit-per-cycle square root unit. A new word is accepted only after the last
// result is emitted; the emit waits while m_ready holds off an earlier result. Reset
// (aresetn, synchronous, active low) clears all tracker state and the output valid.
`timescale 1ns / 1ps

module pose_authority_tracker
    import pat_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [AUTH_W-1:0]    s_sample_authority,
    input  logic                 s_sample_finite,
    input  logic [STAMP_W-1:0]   s_stamp_ms,
    input  logic [POS_W-1:0]     s_pose_x,
    input  logic [POS_W-1:0]     s_pose_y,
    input  logic [YAW_W-1:0]     s_pose_yaw,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [AUTH_W-1:0]    m_authority_now,
    output logic                 m_reference_valid,
    output logic [OUT_CNT_W-1:0] m_predicted_run,
    output logic [STAMP_W-1:0]   m_predicted_duration_ms,
    output logic [OUT_CNT_W-1:0] m_frames_since_ref,
    output logic [STAMP_W-1:0]   m_time_since_ref_ms,
    output logic [DIST_W-1:0]    m_distance_since_ref,
    output logic [YAW_W-1:0]     m_yaw_since_ref,
    output logic [UPD_W-1:0]     m_updates_measured,
    output logic [UPD_W-1:0]     m_updates_predicted
);

    pat_cmd_t    cmd;
    pat_status_t st;

    pat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .st      (st)
    );

    pat_dp u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .st                      (st),
        .s_op                    (s_op),
        .s_sample_authority      (s_sample_authority),
        .s_sample_finite         (s_sample_finite),
        .s_stamp_ms              (s_stamp_ms),
        .s_pose_x                (s_pose_x),
        .s_pose_y                (s_pose_y),
        .s_pose_yaw              (s_pose_yaw),
        .m_authority_now         (m_authority_now),
        .m_reference_valid       (m_reference_valid),
        .m_predicted_run         (m_predicted_run),
        .m_predicted_duration_ms (m_predicted_duration_ms),
        .m_frames_since_ref      (m_frames_since_ref),
        .m_time_since_ref_ms     (m_time_since_ref_ms),
        .m_distance_since_ref    (m_distance_since_ref),
        .m_yaw_since_ref         (m_yaw_since_ref),
        .m_updates_measured      (m_updates_measured),
        .m_updates_predicted     (m_updates_predicted)
    );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for pose_authority_tracker: queue-fed word driver, clocked monitor,
// and an in-bench model of the reference pose, prediction run and map-update counters.
// Depends on pat_pkg and pose_authority_tracker only.
`timescale 1ns / 1ps

module tb;
    import pat_pkg::*;

    localparam int PRE_RUN = 24;      // predicted samples before any reference
    localparam int RANDOM_WORDS = 1600;
    localparam int CHUNK = 200;

    typedef struct packed {
        logic                      op;
        logic [AUTH_W-1:0]         auth;
        logic                      finite;
        logic [STAMP_W-1:0]        stamp;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic [YAW_W-1:0]          yaw;
    } pose_word_t;

    typedef struct packed {
        logic [AUTH_W-1:0]       authority;
        logic                    ref_valid;
        logic [OUT_CNT_W-1:0]    run;
        logic [STAMP_W-1:0]      run_ms;
        logic [OUT_CNT_W-1:0]    frames;
        logic [STAMP_W-1:0]      ref_ms;
        logic [DIST_W-1:0]       dist_mm;
        logic [YAW_W-1:0]        yaw_delta;
        logic [UPD_W-1:0]        upd_meas;
        logic [UPD_W-1:0]        upd_pred;
    } metrics_t;

    typedef struct packed {
        logic [AUTH_W-1:0]       authority;
        logic                    ref_valid;
        logic [STAMP_W-1:0]      ref_stamp;
        logic signed [POS_W-1:0] ref_x;
        logic signed [POS_W-1:0] ref_y;
        logic [YAW_W-1:0]        ref_yaw;
        logic [STAMP_W-1:0]      run_start;
        logic [COUNT_W-1:0]      run_count;
        logic [STAMP_W-1:0]      run_ms;
        logic [COUNT_W-1:0]      frames;
        logic [STAMP_W-1:0]      ref_ms;
        logic [DIST_W-1:0]       dist_mm;
        logic [YAW_W-1:0]        yaw_delta;
        logic [UPD_W-1:0]        upd_meas;
        logic [UPD_W-1:0]        upd_pred;
    } tracker_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_op = OP_SAMPLE;
    logic [AUTH_W-1:0]    s_sample_authority = AUTH_MEASURED;
    logic                 s_sample_finite = 1'b0;
    logic [STAMP_W-1:0]   s_stamp_ms = '0;
    logic [POS_W-1:0]     s_pose_x = '0;
    logic [POS_W-1:0]     s_pose_y = '0;
    logic [YAW_W-1:0]     s_pose_yaw = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [AUTH_W-1:0]    m_authority_now;
    logic                 m_reference_valid;
    logic [OUT_CNT_W-1:0] m_predicted_run;
    logic [STAMP_W-1:0]   m_predicted_duration_ms;
    logic [OUT_CNT_W-1:0] m_frames_since_ref;
    logic [STAMP_W-1:0]   m_time_since_ref_ms;
    logic [DIST_W-1:0]    m_distance_since_ref;
    logic [YAW_W-1:0]     m_yaw_since_ref;
    logic [UPD_W-1:0]     m_updates_measured;
    logic [UPD_W-1:0]     m_updates_predicted;

    pose_word_t pose_words[$];
    metrics_t   metrics_due[$];
    tracker_t   trk = '0;

    logic s_fire = 1'b0;
    logic idle_en = 1'b0;
    logic stall_en = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   words_queued = 0;
    int   words_sent = 0;
    int   results_checked = 0;
    int   errors = 0;

    pose_authority_tracker DUT (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_op                    (s_op),
        .s_sample_authority      (s_sample_authority),
        .s_sample_finite         (s_sample_finite),
        .s_stamp_ms              (s_stamp_ms),
        .s_pose_x                (s_pose_x),
        .s_pose_y                (s_pose_y),
        .s_pose_yaw              (s_pose_yaw),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_authority_now         (m_authority_now),
        .m_reference_valid       (m_reference_valid),
        .m_predicted_run         (m_predicted_run),
        .m_predicted_duration_ms (m_predicted_duration_ms),
        .m_frames_since_ref      (m_frames_since_ref),
        .m_time_since_ref_ms     (m_time_since_ref_ms),
        .m_distance_since_ref    (m_distance_since_ref),
        .m_yaw_since_ref         (m_yaw_since_ref),
        .m_updates_measured      (m_updates_measured),
        .m_updates_predicted     (m_updates_predicted)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [STAMP_W-1:0] elapsed_ms(input logic [STAMP_W-1:0] now,
                                                      input logic [STAMP_W-1:0] from);
        return (now >= from) ? now - from : '0;
    endfunction

    function automatic metrics_t advance_tracker(input pose_word_t w);
        longint signed   dx;
        longint signed   dy;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;
        logic [YAW_W-1:0] turn;
        metrics_t r;
        if (w.op == OP_UPDATE) begin
            if (w.auth == AUTH_MEASURED && trk.upd_meas != '1)
                trk.upd_meas++;
            else if (w.auth == AUTH_PREDICTED && trk.upd_pred != '1)
                trk.upd_pred++;
        end else if (!w.finite) begin
            trk.authority = AUTH_INVALID;
            trk.run_count = '0;
            trk.run_ms    = '0;
            trk.run_start = '0;
        end else if (w.auth == AUTH_MEASURED) begin
            trk.authority = AUTH_MEASURED;
            trk.ref_valid = 1'b1;
            trk.ref_stamp = w.stamp;
            trk.ref_x     = w.x;
            trk.ref_y     = w.y;
            trk.ref_yaw   = w.yaw;
            trk.run_count = '0;
            trk.run_ms    = '0;
            trk.run_start = '0;
            trk.frames    = '0;
            trk.ref_ms    = '0;
            trk.dist_mm   = '0;
            trk.yaw_delta = '0;
        end else begin
            trk.authority = w.auth;
            if (trk.ref_valid) begin
                dx = longint'($signed(w.x)) - longint'($signed(trk.ref_x));
                dy = longint'($signed(w.y)) - longint'($signed(trk.ref_y));
                sq = dx * dx + dy * dy;
                root = 0;
                for (int i = 31; i >= 0; i--) begin
                    trial = root | (64'd1 << i);
                    if (trial * trial <= sq)
                        root = trial;
                end
                if (trk.frames != '1)
                    trk.frames++;
                trk.ref_ms = elapsed_ms(w.stamp, trk.ref_stamp);
                trk.dist_mm = (root > DIST_MAX) ? DIST_MAX : root[DIST_W-1:0];
                turn = w.yaw - trk.ref_yaw;
                trk.yaw_delta = turn[YAW_W-1] ? (~turn + 1'b1) : turn;
            end
            if (w.auth == AUTH_PREDICTED) begin
                if (trk.run_count == '0)
                    trk.run_start = w.stamp;
                if (trk.run_count != '1)
                    trk.run_count++;
                trk.run_ms = elapsed_ms(w.stamp, trk.run_start);
            end else begin
                trk.run_count = '0;
                trk.run_ms    = '0;
                trk.run_start = '0;
            end
        end
        r.authority = trk.authority;
        r.ref_valid = trk.ref_valid;
        r.run       = (trk.run_count > OUT_CNT_MAX) ? OUT_CNT_MAX : trk.run_count;
        r.run_ms    = trk.run_ms;
        r.frames    = (trk.frames > OUT_CNT_MAX) ? OUT_CNT_MAX : trk.frames;
        r.ref_ms    = trk.ref_ms;
        r.dist_mm   = trk.dist_mm;
        r.yaw_delta = trk.yaw_delta;
        r.upd_meas  = trk.upd_meas;
        r.upd_pred  = trk.upd_pred;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic add_word(input logic op, input logic [AUTH_W-1:0] auth, input logic fin,
                            input logic [STAMP_W-1:0] stamp, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [YAW_W-1:0] yaw);
        pose_word_t w;
        w.op = op;
        w.auth = auth;
        w.finite = fin;
        w.stamp = stamp;
        w.x = x;
        w.y = y;
        w.yaw = yaw;
        pose_words.push_back(w);
        words_queued++;
    endtask

    // every queued word accepted and every result back
    task automatic wait_idle();
        do @(negedge aclk);
        while (words_sent != words_queued || metrics_due.size() != 0);
        @(posedge aclk);
    endtask

    // input side driver
    always @(negedge aclk) begin : word_driver
        pose_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pose_words.size() != 0) begin
                w = pose_words.pop_front();
                s_op <= w.op;
                s_sample_authority <= w.auth;
                s_sample_finite <= w.finite;
                s_stamp_ms <= w.stamp;
                s_pose_x <= w.x;
                s_pose_y <= w.y;
                s_pose_yaw <= w.yaw;
                s_valid <= 1'b1;
                gap_left <= idle_en ? pick_gap() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(negedge aclk) begin : result_sink
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (stall_en && $urandom_range(0, 5) == 0) begin
            stall_left <= pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        pose_word_t w;
        metrics_t want;
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                w.op = s_op;
                w.auth = s_sample_authority;
                w.finite = s_sample_finite;
                w.stamp = s_stamp_ms;
                w.x = s_pose_x;
                w.y = s_pose_y;
                w.yaw = s_pose_yaw;
                metrics_due.push_back(advance_tracker(w));
                words_sent++;
            end
            if (m_valid && m_ready) begin
                if (metrics_due.size() == 0) begin
                    $error("result word with nothing outstanding");
                    errors++;
                end else begin
                    want = metrics_due.pop_front();
                    check_field("authority_now", 64'(want.authority),
                                64'(m_authority_now));
                    check_field("reference_valid", 64'(want.ref_valid),
                                64'(m_reference_valid));
                    check_field("predicted_run", 64'(want.run), 64'(m_predicted_run));
                    check_field("predicted_duration_ms", 64'(want.run_ms),
                                64'(m_predicted_duration_ms));
                    check_field("frames_since_ref", 64'(want.frames),
                                64'(m_frames_since_ref));
                    check_field("time_since_ref_ms", 64'(want.ref_ms),
                                64'(m_time_since_ref_ms));
                    check_field("distance_since_ref", 64'(want.dist_mm),
                                64'(m_distance_since_ref));
                    check_field("yaw_since_ref", 64'(want.yaw_delta),
                                64'(m_yaw_since_ref));
                    check_field("updates_measured", 64'(want.upd_meas),
                                64'(m_updates_measured));
                    check_field("updates_predicted", 64'(want.upd_pred),
                                64'(m_updates_predicted));
                    results_checked++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [STAMP_W-1:0] cstamp;
        logic [POS_W-1:0]   cx;
        logic [POS_W-1:0]   cy;
        logic [YAW_W-1:0]   cyaw;
        logic [AUTH_W-1:0]  auth;
        int r;

        // predicted run before any reference exists
        cstamp = 32'd5;
        for (int i = 0; i < PRE_RUN; i++) begin
            cstamp = cstamp + $urandom_range(0, 3);
            add_word(OP_SAMPLE, AUTH_PREDICTED, 1'b1, cstamp, POS_W'($urandom),
                     POS_W'($urandom), YAW_W'($urandom));
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        wait_idle();

        idle_en = 1'b1;
        stall_en = 1'b1;
        add_word(OP_UPDATE, AUTH_MEASURED, 1'b0, '0, '0, '0, '0);
        add_word(OP_UPDATE, AUTH_PREDICTED, 1'b1, '1, '1, '1, '1);
        add_word(OP_UPDATE, AUTH_RECOVERY, 1'b1, '0, '0, '0, '0);
        add_word(OP_UPDATE, AUTH_INVALID, 1'b0, '1, '1, '1, '1);
        // no reference yet
        add_word(OP_SAMPLE, AUTH_RECOVERY, 1'b1, 32'd100, 24'h123456, 24'h654321, 16'h1234);
        add_word(OP_SAMPLE, AUTH_PREDICTED, 1'b1, 32'd200, '0, '0, '0);
        add_word(OP_SAMPLE, AUTH_MEASURED, 1'b0, 32'd300, '0, '0, '0);
        // reference at one corner, then the far corner at a half turn
        add_word(OP_SAMPLE, AUTH_MEASURED, 1'b1, 32'd1000, 24'h800000, 24'h7FFFFF, 16'h0000);
        add_word(OP_SAMPLE, AUTH_PREDICTED, 1'b1, 32'd2000, 24'h7FFFFF, 24'h800000, 16'h8000);
        // time going backwards
        add_word(OP_SAMPLE, AUTH_PREDICTED, 1'b1, 32'd500, 24'h7FFFFF, 24'h800000, 16'h8001);
        add_word(OP_SAMPLE, AUTH_RECOVERY, 1'b1, 32'hFFFF_0000, 24'h000000, 24'h000000, 16'hFFFF);
        add_word(OP_SAMPLE, AUTH_INVALID, 1'b1, 32'hFFFF_FFFF, 24'h800000, 24'h7FFFFF, 16'h7FFF);
        add_word(OP_SAMPLE, AUTH_PREDICTED, 1'b0, 32'd3000, 24'h000001, 24'h000001, 16'h0001);
        add_word(OP_SAMPLE, AUTH_PREDICTED, 1'b1, 32'd3000, 24'h800000, 24'h7FFFFF, 16'h0000);
        add_word(OP_SAMPLE, AUTH_MEASURED, 1'b1, 32'hFFFF_FFFF, '0, '0, 16'hFFFF);
        add_word(OP_SAMPLE, AUTH_PREDICTED, 1'b1, 32'd0, 24'h000003, 24'hFFFFFC, 16'h7FFF);
        add_word(OP_SAMPLE, AUTH_PREDICTED, 1'b1, 32'hFFFF_FFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFE);
        add_word(OP_UPDATE, AUTH_PREDICTED, 1'b0, '0, '0, '0, '0);
        add_word(OP_UPDATE, AUTH_MEASURED, 1'b1, '1, '1, '1, '1);
        wait_idle();

        // random part: mostly plausible trajectories, some noise
        cstamp = $urandom;
        cx = POS_W'($urandom);
        cy = POS_W'($urandom);
        cyaw = YAW_W'($urandom);
        for (int c = 0; c < RANDOM_WORDS / CHUNK; c++) begin
            idle_en = ($urandom_range(0, 3) != 0);
            stall_en = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < CHUNK; i++) begin
                cstamp = cstamp + $urandom_range(0, 120);
                if ($urandom_range(0, 24) == 0)
                    cstamp = cstamp - $urandom_range(0, 5000);
                if ($urandom_range(0, 199) == 0)
                    cstamp = 32'hFFFF_F000 + $urandom_range(0, 4095);
                cx = POS_W'(cx + $urandom_range(0, 2000) - 1000);
                cy = POS_W'(cy + $urandom_range(0, 2000) - 1000);
                cyaw = YAW_W'(cyaw + $urandom_range(0, 4000) - 2000);
                if ($urandom_range(0, 19) == 0) begin
                    cx = POS_W'($urandom);
                    cy = POS_W'($urandom);
                    cyaw = YAW_W'($urandom);
                end
                auth = AUTH_W'($urandom);
                r = $urandom_range(0, 99);
                if (r < 10)
                    add_word(OP_SAMPLE, AUTH_MEASURED, 1'b1, cstamp, cx, cy, cyaw);
                else if (r < 55)
                    add_word(OP_SAMPLE, AUTH_PREDICTED, 1'b1, cstamp, cx, cy, cyaw);
                else if (r < 65)
                    add_word(OP_SAMPLE, AUTH_RECOVERY, 1'b1, cstamp, cx, cy, cyaw);
                else if (r < 70)
                    add_word(OP_SAMPLE, AUTH_INVALID, 1'b1, cstamp, cx, cy, cyaw);
                else if (r < 78)
                    add_word(OP_SAMPLE, auth, 1'b0, cstamp, cx, cy, cyaw);
                else if (r < 90)
                    add_word(OP_UPDATE, auth, 1'($urandom), $urandom, POS_W'($urandom),
                             POS_W'($urandom), YAW_W'($urandom));
                else
                    add_word(1'($urandom), auth, 1'($urandom), $urandom, POS_W'($urandom),
                             POS_W'($urandom), YAW_W'($urandom));
            end
            if ($urandom_range(0, 1) == 0)
                wait_idle();
        end
        wait_idle();
        repeat (64) @(posedge aclk);

        $display("summary: %0d words in, %0d result words checked, %0d-sample run before a reference",
                 words_sent, results_checked, PRE_RUN);
        $display("summary: directed corners, backwards time, half turns, updates by authority");
        if (errors == 0 && metrics_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/pat_pkg.sv
hw/rtl/pat_sqrt.sv
hw/rtl/pat_dp.sv
hw/rtl/pat_ctrl.sv
hw/rtl/pose_authority_tracker.sv
verif/tb.sv
